// File: rtl/sqvt_pkg.sv
// Shared constants and types for the sprite quad vertex transform.
`default_nettype none
package sqvt_pkg;

	localparam int COORD_WIDTH_DEF    = 20;
	localparam int TRIG_FRAC_BITS_DEF = 14;

	localparam int ANGLE_WIDTH = 15;
	localparam int SCALE_WIDTH = 16;
	localparam int SIZE_WIDTH  = 16;

	// angle units are 1/32 degree
	localparam logic signed [15:0] ANGLE_FULL    = 16'sd11520;
	localparam logic signed [15:0] ANGLE_HALF    = 16'sd5760;
	localparam logic signed [15:0] ANGLE_3QUART  = 16'sd8640;
	localparam logic signed [15:0] ANGLE_QUARTER = 16'sd2880;
	localparam logic [10:0]        ANGLE_EIGHTH  = 11'd1440;

	// radians per angle unit, Q40
	localparam logic [29:0] RAD_PER_UNIT = 30'd599690565;
	localparam logic [30:0] ONE_Q30      = 31'h4000_0000;

	// Taylor divisors and floor(2^32 / d)
	localparam int NUM_DIV = 6;
	localparam logic [15:0] DIVISOR [NUM_DIV] = '{16'd6, 16'd24, 16'd120, 16'd720,
		16'd5040, 16'd40320};
	localparam logic [29:0] RECIP [NUM_DIV] = '{30'd715827882, 30'd178956970,
		30'd35791394, 30'd5965232, 30'd852176, 30'd106522};

	typedef enum logic [2:0] {
		REG_PIVOT_X,
		REG_PIVOT_Y,
		REG_SCALE_X,
		REG_SCALE_Y,
		REG_QUAD_WIDTH,
		REG_QUAD_HEIGHT,
		REG_ROT_ANGLE
	} reg_idx_t;

	localparam int REG_IDX_WIDTH = 3;

endpackage
`default_nettype wire

// File: rtl/sprite_quad_vertex_transform_top.sv
// Top level: config registers, corner geometry pipeline, rotation and corner serializer.
//
//  channel   direction  handshake              payload
//  config    in         wr_en                  wr_index, wr_data
//  sprite    in         in_valid / in_stall    cmd, pos_x, pos_y, right_edge, bottom_edge
//  corner    out        out_valid / out_stall  corner_index, vert_x, vert_y, last
//
// A sprite transaction yields four corner transactions, one per cycle unless out_stall
// is high, so a new sprite is taken only when the serializer is idle or on its last corner.
// First corner follows the geometry stages (matched to the trig pipeline) and the serializer.
// Reset clears the valid bits, the serializer and all config registers but the scales, set to 4096.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module sprite_quad_vertex_transform_top #(
	parameter int COORD_WIDTH    = sqvt_pkg::COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = sqvt_pkg::TRIG_FRAC_BITS_DEF
) (
	input  wire logic                                                    clk,
	input  wire logic                                                    arst_n,
	input  wire logic                                                    wr_en,
	input  wire logic [sqvt_pkg::REG_IDX_WIDTH-1:0]                      wr_index,
	input  wire logic [((COORD_WIDTH > 16) ? COORD_WIDTH : 16)-1:0]      wr_data,
	input  wire logic                                                    in_valid,
	output logic                                                         in_stall,
	input  wire logic                                                    cmd,
	input  wire logic signed [COORD_WIDTH-1:0]                           pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]                           pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]                           right_edge,
	input  wire logic signed [COORD_WIDTH-1:0]                           bottom_edge,
	output logic                                                         out_valid,
	input  wire logic                                                    out_stall,
	output logic [1:0]                                                   corner_index,
	output logic signed [COORD_WIDTH-1:0]                                vert_x,
	output logic signed [COORD_WIDTH-1:0]                                vert_y,
	output logic                                                         last
);
	import sqvt_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int PW = CW + 5;
	localparam int XW = ((CW + 6 > 22) ? CW + 6 : 22) + 1;
	localparam int DW = XW + 1;
	localparam int MW = DW + TW;
	localparam int SW = MW + 2;
	localparam longint SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
	localparam longint SAT_LO = -SAT_HI - 64'sd1;
	localparam logic signed [XW-1:0] HALF_PIX = XW'(8);
	localparam logic signed [SW-1:0] ROT_RND = SW'(1) <<< (TRIG_FRAC_BITS - 1);
	localparam int LAST_GEO = 10;

	typedef struct packed {
		logic                 rot;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [XW-1:0] x0;
		logic signed [XW-1:0] x1;
		logic signed [XW-1:0] y0;
		logic signed [XW-1:0] y1;
	} geo_t;

	// config registers
	logic signed [CW-1:0]          pivot_x_q, pivot_y_q;
	logic [SCALE_WIDTH-1:0]        scale_x_q, scale_y_q;
	logic [SIZE_WIDTH-1:0]         quad_w_q, quad_h_q;
	logic signed [ANGLE_WIDTH-1:0] rot_angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_x_q   <= '0;
			pivot_y_q   <= '0;
			scale_x_q   <= SCALE_WIDTH'(4096);
			scale_y_q   <= SCALE_WIDTH'(4096);
			quad_w_q    <= '0;
			quad_h_q    <= '0;
			rot_angle_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_PIVOT_X:     pivot_x_q   <= wr_data[CW-1:0];
				REG_PIVOT_Y:     pivot_y_q   <= wr_data[CW-1:0];
				REG_SCALE_X:     scale_x_q   <= wr_data[SCALE_WIDTH-1:0];
				REG_SCALE_Y:     scale_y_q   <= wr_data[SCALE_WIDTH-1:0];
				REG_QUAD_WIDTH:  quad_w_q    <= wr_data[SIZE_WIDTH-1:0];
				REG_QUAD_HEIGHT: quad_h_q    <= wr_data[SIZE_WIDTH-1:0];
				REG_ROT_ANGLE:   rot_angle_q <= wr_data[ANGLE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic ser_valid_q;
	logic [1:0] beat_q;
	logic [12:1] vld_s;

	assign en       = !ser_valid_q || (!out_stall && beat_q == 2'd3);
	assign in_stall = !en;

	// stage 1: input capture, pivot and size scaling
	logic cmd_s1, rot_s1;
	logic signed [CW-1:0] px_s1, py_s1, re_s1, be_s1;
	logic signed [PW-1:0] pvx_s1, pvy_s1;
	logic [20:0] wsx_s1, wsy_s1;
	logic signed [CW+16:0] ppx_w, ppy_w;
	logic [32:0] wpx_w, wpy_w;

	assign ppx_w = pivot_x_q * $signed({1'b0, scale_x_q});
	assign ppy_w = pivot_y_q * $signed({1'b0, scale_y_q});
	assign wpx_w = 33'(quad_w_q) * 33'(scale_x_q) + 33'd2048;
	assign wpy_w = 33'(quad_h_q) * 33'(scale_y_q) + 33'd2048;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd;
			rot_s1 <= !cmd && (rot_angle_q != '0);
			px_s1  <= pos_x;
			py_s1  <= pos_y;
			re_s1  <= right_edge;
			be_s1  <= bottom_edge;
			pvx_s1 <= PW'((ppx_w + (CW+17)'(2048)) >>> 12);
			pvy_s1 <= PW'((ppy_w + (CW+17)'(2048)) >>> 12);
			wsx_s1 <= wpx_w[32:12];
			wsy_s1 <= wpy_w[32:12];
		end
	end

	// stage 2: unrotated corners, then delayed to meet the trig result
	geo_t geo_w;
	geo_t geo_s [2:LAST_GEO];

	always_comb begin
		geo_w.rot = rot_s1;
		geo_w.px  = px_s1;
		geo_w.py  = py_s1;
		if (cmd_s1) begin
			geo_w.x0 = XW'(px_s1) - HALF_PIX;
			geo_w.y0 = XW'(py_s1) - HALF_PIX;
			geo_w.x1 = XW'(re_s1) - HALF_PIX;
			geo_w.y1 = XW'(be_s1) - HALF_PIX;
		end else begin
			geo_w.x0 = XW'(px_s1) - XW'(pvx_s1) - HALF_PIX;
			geo_w.y0 = XW'(py_s1) - XW'(pvy_s1) - HALF_PIX;
			geo_w.x1 = geo_w.x0 + $signed(XW'(wsx_s1));
			geo_w.y1 = geo_w.y0 + $signed(XW'(wsy_s1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s[2] <= geo_w;
			for (int k = 3; k <= LAST_GEO; k++)
				geo_s[k] <= geo_s[k-1];
		end
	end

	logic signed [TW-1:0] sn_s10, cs_s10;

	sqvt_trig #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_trig (
		.clk  (clk),
		.en   (en),
		.angle(rot_angle_q),
		.sn   (sn_s10),
		.cs   (cs_s10)
	);

	// stage 11: rotation products
	logic signed [DW-1:0] dx0_w, dx1_w, dy0_w, dy1_w;
	logic signed [MW-1:0] xc_s11 [2], xs_s11 [2], yc_s11 [2], ys_s11 [2];
	geo_t geo_s11;

	assign dx0_w = DW'(geo_s[LAST_GEO].x0) - DW'(geo_s[LAST_GEO].px);
	assign dx1_w = DW'(geo_s[LAST_GEO].x1) - DW'(geo_s[LAST_GEO].px);
	assign dy0_w = DW'(geo_s[LAST_GEO].y0) - DW'(geo_s[LAST_GEO].py);
	assign dy1_w = DW'(geo_s[LAST_GEO].y1) - DW'(geo_s[LAST_GEO].py);

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s11   <= geo_s[LAST_GEO];
			xc_s11[0] <= dx0_w * cs_s10;
			xc_s11[1] <= dx1_w * cs_s10;
			xs_s11[0] <= dx0_w * sn_s10;
			xs_s11[1] <= dx1_w * sn_s10;
			yc_s11[0] <= dy0_w * cs_s10;
			yc_s11[1] <= dy1_w * cs_s10;
			ys_s11[0] <= dy0_w * sn_s10;
			ys_s11[1] <= dy1_w * sn_s10;
		end
	end

	// stage 12: corner sums and saturation
	logic signed [CW-1:0] cx_w [4], cy_w [4];
	logic signed [CW-1:0] cx_s12 [4], cy_s12 [4];

	always_comb begin
		logic signed [SW-1:0] rx, ry;
		for (int k = 0; k < 4; k++) begin
			if (geo_s11.rot) begin
				rx = SW'(geo_s11.px) + ((SW'(xc_s11[k%2]) - SW'(ys_s11[k/2]) + ROT_RND)
					>>> TRIG_FRAC_BITS);
				ry = SW'(geo_s11.py) + ((SW'(xs_s11[k%2]) + SW'(yc_s11[k/2]) + ROT_RND)
					>>> TRIG_FRAC_BITS);
			end else begin
				rx = (k % 2 == 1) ? SW'(geo_s11.x1) : SW'(geo_s11.x0);
				ry = (k / 2 == 1) ? SW'(geo_s11.y1) : SW'(geo_s11.y0);
			end
			if (rx > SW'(SAT_HI))
				cx_w[k] = CW'(SAT_HI);
			else if (rx < SW'(SAT_LO))
				cx_w[k] = CW'(SAT_LO);
			else
				cx_w[k] = CW'(rx);
			if (ry > SW'(SAT_HI))
				cy_w[k] = CW'(SAT_HI);
			else if (ry < SW'(SAT_LO))
				cy_w[k] = CW'(SAT_LO);
			else
				cy_w[k] = CW'(ry);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				cx_s12[k] <= cx_w[k];
				cy_s12[k] <= cy_w[k];
			end
		end
	end

	// valid bits and output serializer
	logic signed [CW-1:0] ser_x_q [4], ser_y_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			ser_valid_q <= 1'b0;
			beat_q      <= 2'd0;
		end else if (en) begin
			vld_s       <= {vld_s[11:1], in_valid};
			ser_valid_q <= vld_s[12];
			beat_q      <= 2'd0;
		end else if (!out_stall) begin
			beat_q <= beat_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				ser_x_q[k] <= cx_s12[k];
				ser_y_q[k] <= cy_s12[k];
			end
		end
	end

	assign out_valid    = ser_valid_q;
	assign corner_index = beat_q;
	assign vert_x       = ser_x_q[beat_q];
	assign vert_y       = ser_y_q[beat_q];
	assign last         = (beat_q == 2'd3);

endmodule
`default_nettype wire

// File: rtl/sqvt_trig.sv
// Pipelined sine/cosine of the rotation angle: octant fold, Q30 Taylor series, rounding.
`default_nettype none
module sqvt_trig #(
	parameter int TRIG_FRAC_BITS = sqvt_pkg::TRIG_FRAC_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       en,
	input  wire logic signed [sqvt_pkg::ANGLE_WIDTH-1:0]    angle,
	output logic signed [TRIG_FRAC_BITS+1:0]                sn,
	output logic signed [TRIG_FRAC_BITS+1:0]                cs
);
	import sqvt_pkg::*;

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam logic [32:0] TRND = 33'd1 << (29 - TRIG_FRAC_BITS);

	function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [29:0] b);
		logic [59:0] p;
		p = 60'(a) * 60'(b);
		return p[59:30];
	endfunction

	function automatic logic [29:0] recip_q(input logic [29:0] x, input logic [29:0] m);
		logic [59:0] p;
		p = 60'(x) * 60'(m);
		return 30'(p[59:32]);
	endfunction

	// estimate is exact or one low
	function automatic logic [29:0] fix_q(input logic [29:0] x, input logic [29:0] q0,
			input logic [15:0] d);
		logic [45:0] rm;
		rm = 46'(x) - 46'(q0) * 46'(d);
		return (rm >= 46'(d)) ? q0 + 30'd1 : q0;
	endfunction

	logic signed [15:0] a_w;
	logic [1:0]         quad_w;
	logic signed [15:0] r_w;
	logic               fold_w;
	logic [10:0]        rf_w;

	always_comb begin
		a_w = 16'(angle);
		if (a_w < 16'sd0)
			a_w = a_w + ANGLE_FULL;
		if (a_w < 16'sd0)
			a_w = a_w + ANGLE_FULL;
		if (a_w >= ANGLE_FULL)
			a_w = a_w - ANGLE_FULL;
		if (a_w < ANGLE_QUARTER) begin
			quad_w = 2'd0;
			r_w = a_w;
		end else if (a_w < ANGLE_HALF) begin
			quad_w = 2'd1;
			r_w = a_w - ANGLE_QUARTER;
		end else if (a_w < ANGLE_3QUART) begin
			quad_w = 2'd2;
			r_w = a_w - ANGLE_HALF;
		end else begin
			quad_w = 2'd3;
			r_w = a_w - ANGLE_3QUART;
		end
		// remainder runs up to a quarter turn, wider than 11 bits
		fold_w = r_w > $signed({5'd0, ANGLE_EIGHTH});
		rf_w = fold_w ? 11'(ANGLE_QUARTER - r_w) : r_w[10:0];
	end

	logic [10:0] r_s1;
	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6, quad_s7, quad_s8,
		quad_s9;
	logic        fold_s1, fold_s2, fold_s3, fold_s4, fold_s5, fold_s6, fold_s7, fold_s8,
		fold_s9;
	logic [29:0] t_s2, t_s3, t_s4, t_s5, t_s6, t_s7, t_s8;
	logic [29:0] t2_s3, t2_s4, t2_s5, t2_s6, t2_s7, t2_s8;
	logic [29:0] t3_s4, t4_s4, t3_s5, t4_s5, t5_s5, t6_s5, t8_s5;
	logic [29:0] pw_s6 [NUM_DIV];
	logic [29:0] x_s7 [NUM_DIV];
	logic [29:0] q_s7 [NUM_DIV];
	logic [29:0] dq_s8 [NUM_DIV];
	logic signed [TW-1:0] s0_s9, c0_s9;
	logic [40:0] rad_w;
	logic signed [32:0] sv_w, cv_w;
	logic signed [TW-1:0] fs_w, fc_w;

	assign rad_w = 41'(r_s1) * 41'(RAD_PER_UNIT);

	always_comb begin
		sv_w = 33'(t_s8) - 33'(dq_s8[0]) + 33'(dq_s8[2]) - 33'(dq_s8[4]) + TRND;
		cv_w = 33'(ONE_Q30) - 33'(t2_s8 >> 1) + 33'(dq_s8[1]) - 33'(dq_s8[3])
			+ 33'(dq_s8[5]) + TRND;
		fs_w = fold_s9 ? c0_s9 : s0_s9;
		fc_w = fold_s9 ? s0_s9 : c0_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= rf_w;
			quad_s1 <= quad_w;
			fold_s1 <= fold_w;

			t_s2    <= rad_w[39:10];
			quad_s2 <= quad_s1;
			fold_s2 <= fold_s1;

			t_s3    <= t_s2;
			t2_s3   <= mul_q30(t_s2, t_s2);
			quad_s3 <= quad_s2;
			fold_s3 <= fold_s2;

			t_s4    <= t_s3;
			t2_s4   <= t2_s3;
			t3_s4   <= mul_q30(t2_s3, t_s3);
			t4_s4   <= mul_q30(t2_s3, t2_s3);
			quad_s4 <= quad_s3;
			fold_s4 <= fold_s3;

			t_s5    <= t_s4;
			t2_s5   <= t2_s4;
			t3_s5   <= t3_s4;
			t4_s5   <= t4_s4;
			t5_s5   <= mul_q30(t4_s4, t_s4);
			t6_s5   <= mul_q30(t4_s4, t2_s4);
			t8_s5   <= mul_q30(t4_s4, t4_s4);
			quad_s5 <= quad_s4;
			fold_s5 <= fold_s4;

			t_s6     <= t_s5;
			t2_s6    <= t2_s5;
			pw_s6[0] <= t3_s5;
			pw_s6[1] <= t4_s5;
			pw_s6[2] <= t5_s5;
			pw_s6[3] <= t6_s5;
			pw_s6[4] <= mul_q30(t6_s5, t_s5);
			pw_s6[5] <= t8_s5;
			quad_s6  <= quad_s5;
			fold_s6  <= fold_s5;

			t_s7    <= t_s6;
			t2_s7   <= t2_s6;
			for (int k = 0; k < NUM_DIV; k++) begin
				x_s7[k] <= pw_s6[k];
				q_s7[k] <= recip_q(pw_s6[k], RECIP[k]);
			end
			quad_s7 <= quad_s6;
			fold_s7 <= fold_s6;

			t_s8    <= t_s7;
			t2_s8   <= t2_s7;
			for (int k = 0; k < NUM_DIV; k++)
				dq_s8[k] <= fix_q(x_s7[k], q_s7[k], DIVISOR[k]);
			quad_s8 <= quad_s7;
			fold_s8 <= fold_s7;

			s0_s9   <= TW'(sv_w >>> (30 - TRIG_FRAC_BITS));
			c0_s9   <= TW'(cv_w >>> (30 - TRIG_FRAC_BITS));
			quad_s9 <= quad_s8;
			fold_s9 <= fold_s8;

			case (quad_s9)
				2'd0: begin
					sn <= fs_w;
					cs <= fc_w;
				end
				2'd1: begin
					sn <= fc_w;
					cs <= -fs_w;
				end
				2'd2: begin
					sn <= -fs_w;
					cs <= -fc_w;
				end
				default: begin
					sn <= -fc_w;
					cs <= fs_w;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
